### design/aspe_pkg.sv
// aspe_pkg: sizes, scan phases and unit kinds for the annex b parameter set extractor
// no dependencies; imported by the top level
package aspe_pkg;

  localparam int SEQ_MAX_BYTES = 128;
  localparam int PIC_MAX_BYTES = 64;

  // one address bit selects the bank, the rest index within a unit
  localparam int SEQ_IW = $clog2(SEQ_MAX_BYTES);
  localparam int PIC_IW = $clog2(PIC_MAX_BYTES);
  localparam int SEQ_AW = SEQ_IW + 1;
  localparam int PIC_AW = PIC_IW + 1;

  localparam logic [7:0] NAL_TYPE_MASK = 8'h1f;
  localparam logic [4:0] NAL_TYPE_SPS  = 5'd7;
  localparam logic [4:0] NAL_TYPE_PPS  = 5'd8;

  localparam logic [1:0] PH_SEARCH = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_UNIT   = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_SEQ  = 2'd1;
  localparam logic [1:0] KIND_PIC  = 2'd2;

  localparam logic REQ_STREAM = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  localparam logic STORE_SEQ = 1'b0;
  localparam logic STORE_PIC = 1'b1;

  // write and read request into one bank ram
  typedef struct packed {
    logic             we;
    logic [SEQ_AW-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [SEQ_AW-1:0] raddr;
  } aspe_ram_req_t;

endpackage

### design/aspe_bank_ram.sv
// aspe_bank_ram: generic single-write, single-read byte ram, registered read data
// no dependencies; holds both banks of one parameter set store
module aspe_bank_ram #(
  parameter int AW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/annexb_sps_pps_extractor_core.sv
// annexb_sps_pps_extractor_core: start code scanner, nal classifier and banked sps/pps capture
// depends on aspe_pkg and aspe_bank_ram
//
//  channel | dir | words                    | result
//  in_     | in  | stream byte or read req  | read req and last stream byte give one word
//  out_    | out | read reply or status     | one word per result
//
// one word is accepted per cycle while in_tready is high; a result passes through the
// registered store read and then the output register before it leaves.
// scan state and held lengths are flip-flops, stored bytes live in two bank rams.
// rst_n is synchronous; it clears the scanner, lengths and bank selects, ram is not cleared.
// a stall on out_tready backs up through the single middle stage to in_tready.
module annexb_sps_pps_extractor_core
  import aspe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // data_byte[7:0], read_kind[8], read_index[15:9]
  input  logic        in_tuser,   // req_type
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // read_data[7:0], seq_set_length[15:8],
                                  // pic_set_length[22:16], found_both[23]
  output logic        out_tuser   // is_read_reply
);

  logic [1:0] zero_run_r, zero_run_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic [7:0] count_r, count_nxt;
  logic [7:0] seq_len_r, seq_len_nxt;
  logic [6:0] pic_len_r, pic_len_nxt;
  logic [1:0] bank_r, bank_nxt;

  logic       p1_valid_r, p1_reply_r, p1_store_r, p1_hit_r;
  logic [7:0] p1_seq_len_r;
  logic [6:0] p1_pic_len_r;
  logic [7:0] p1_rd;
  logic       res_en, res_reply, res_hit;
  logic [7:0] res_seq_len;
  logic [6:0] res_pic_len;

  logic        out_valid_r;
  logic [23:0] out_tdata_r;
  logic        out_tuser_r;

  aspe_ram_req_t seq_req, pic_req;
  logic [7:0]    seq_q, pic_q;

  logic       accept, p1_move;
  logic [7:0] b;
  logic       last, rd_store;
  logic [6:0] rd_index;

  assign p1_move   = !out_valid_r || out_tready;
  assign in_tready = !p1_valid_r || p1_move;
  assign accept    = in_tvalid && in_tready;

  assign b        = in_tdata[7:0];
  assign rd_store = in_tdata[8];
  assign rd_index = in_tdata[15:9];
  assign last     = in_tlast;

  always_comb begin
    logic       start;
    logic [1:0] zr_sat;
    logic [1:0] ph_up;
    logic [1:0] kd_up;
    logic [7:0] cnt_up;
    logic [7:0] cap;
    logic       wr_en;
    logic [7:0] wr_idx;
    logic       end_en;
    logic [7:0] end_len;
    logic [1:0] end_kind;
    logic [4:0] nal_t;

    zero_run_nxt = zero_run_r;
    phase_nxt    = phase_r;
    kind_nxt     = kind_r;
    count_nxt    = count_r;
    seq_len_nxt  = seq_len_r;
    pic_len_nxt  = pic_len_r;
    bank_nxt     = bank_r;
    res_en       = 1'b0;
    res_reply    = 1'b0;
    res_hit      = 1'b0;
    seq_req      = '0;
    pic_req      = '0;

    start  = (b == 8'd1) && (zero_run_r >= 2'd2);
    zr_sat = (b != 8'd0) ? 2'd0 : ((zero_run_r < 2'd3) ? zero_run_r + 2'd1 : 2'd3);
    nal_t  = 5'(b & NAL_TYPE_MASK);
    ph_up  = phase_r;
    kd_up  = kind_r;
    cnt_up = count_r;
    wr_en  = 1'b0;
    wr_idx = count_r;
    end_en = 1'b0;
    end_len = 8'd0;
    end_kind = kind_r;

    case (kind_r)
      KIND_SEQ: cap = 8'(SEQ_MAX_BYTES + 3);
      KIND_PIC: cap = 8'(PIC_MAX_BYTES + 3);
      default:  cap = 8'd3;
    endcase

    if (accept && in_tuser == REQ_READ) begin
      res_en    = 1'b1;
      res_reply = 1'b1;
      if (rd_store == STORE_SEQ) begin
        res_hit       = {1'b0, rd_index} < seq_len_r;
        seq_req.re    = 1'b1;
        seq_req.raddr = {bank_r[0], rd_index[SEQ_IW-1:0]};
      end else begin
        res_hit       = rd_index < pic_len_r;
        pic_req.re    = 1'b1;
        pic_req.raddr = SEQ_AW'({bank_r[1], rd_index[PIC_IW-1:0]});
      end
    end else if (accept) begin
      case (phase_r)
        PH_SEARCH: begin
          seq_len_nxt = 8'd0;
          pic_len_nxt = 7'd0;
          if (start) begin
            ph_up        = PH_HEADER;
            zero_run_nxt = 2'd0;
          end else begin
            zero_run_nxt = zr_sat;
          end
        end
        PH_HEADER: begin
          kd_up = (nal_t == NAL_TYPE_SPS) ? KIND_SEQ :
                  (nal_t == NAL_TYPE_PPS) ? KIND_PIC : KIND_NONE;
          cnt_up       = 8'd1;
          wr_en        = 1'b1;
          wr_idx       = 8'd0;
          zero_run_nxt = (b == 8'd0) ? 2'd1 : 2'd0;
          ph_up        = PH_UNIT;
        end
        PH_UNIT: begin
          if (start) begin
            end_en       = 1'b1;
            end_len      = count_r - 8'd2;
            end_kind     = kind_r;
            zero_run_nxt = 2'd0;
            ph_up        = PH_HEADER;
          end else begin
            wr_en        = 1'b1;
            wr_idx       = count_r;
            if (count_r < cap) begin
              cnt_up = count_r + 8'd1;
            end
            zero_run_nxt = zr_sat;
          end
        end
        default: begin
        end
      endcase

      // a buffer that ends inside a unit closes it at its full length
      if (last && ph_up == PH_UNIT) begin
        end_en   = 1'b1;
        end_len  = cnt_up;
        end_kind = kd_up;
      end

      // bytes go to the bank that is not being read out
      if (wr_en && kd_up == KIND_SEQ && wr_idx < 8'(SEQ_MAX_BYTES)) begin
        seq_req.we    = 1'b1;
        seq_req.waddr = {~bank_r[0], wr_idx[SEQ_IW-1:0]};
        seq_req.wdata = b;
      end else if (wr_en && kd_up == KIND_PIC && wr_idx < 8'(PIC_MAX_BYTES)) begin
        pic_req.we    = 1'b1;
        pic_req.waddr = SEQ_AW'({~bank_r[1], wr_idx[PIC_IW-1:0]});
        pic_req.wdata = b;
      end

      kind_nxt  = kd_up;
      count_nxt = cnt_up;
      if (end_en) begin
        if (end_kind == KIND_SEQ && end_len != 8'd0 && end_len <= 8'(SEQ_MAX_BYTES)) begin
          bank_nxt[0] = ~bank_r[0];
          seq_len_nxt = end_len;
        end else if (end_kind == KIND_PIC && end_len != 8'd0
                     && end_len <= 8'(PIC_MAX_BYTES)) begin
          bank_nxt[1] = ~bank_r[1];
          pic_len_nxt = end_len[6:0];
        end
        kind_nxt  = KIND_NONE;
        count_nxt = 8'd0;
      end

      // capture stops once both sets are held
      if (phase_r == PH_UNIT && start && seq_len_nxt != 8'd0 && pic_len_nxt != 7'd0) begin
        ph_up = PH_DONE;
      end
      phase_nxt = ph_up;

      if (last) begin
        res_en       = 1'b1;
        zero_run_nxt = 2'd0;
        kind_nxt     = KIND_NONE;
        count_nxt    = 8'd0;
        phase_nxt    = PH_SEARCH;
      end
    end

    res_seq_len = seq_len_nxt;
    res_pic_len = pic_len_nxt;
  end

  aspe_bank_ram #(.AW(SEQ_AW)) u_seq_ram (
    .clk   (clk),
    .we    (seq_req.we),
    .waddr (seq_req.waddr),
    .wdata (seq_req.wdata),
    .re    (seq_req.re),
    .raddr (seq_req.raddr),
    .rdata (seq_q)
  );

  aspe_bank_ram #(.AW(PIC_AW)) u_pic_ram (
    .clk   (clk),
    .we    (pic_req.we),
    .waddr (pic_req.waddr[PIC_AW-1:0]),
    .wdata (pic_req.wdata),
    .re    (pic_req.re),
    .raddr (pic_req.raddr[PIC_AW-1:0]),
    .rdata (pic_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_run_r  <= 2'd0;
      phase_r     <= PH_SEARCH;
      kind_r      <= KIND_NONE;
      count_r     <= 8'd0;
      seq_len_r   <= 8'd0;
      pic_len_r   <= 7'd0;
      bank_r      <= 2'd0;
      p1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      zero_run_r <= zero_run_nxt;
      phase_r    <= phase_nxt;
      kind_r     <= kind_nxt;
      count_r    <= count_nxt;
      seq_len_r  <= seq_len_nxt;
      pic_len_r  <= pic_len_nxt;
      bank_r     <= bank_nxt;
      if (in_tready) begin
        p1_valid_r <= res_en;
      end
      if (p1_move) begin
        out_valid_r <= p1_valid_r;
      end
    end
  end

  assign p1_rd = !(p1_reply_r && p1_hit_r) ? 8'd0 : (p1_store_r == STORE_PIC) ? pic_q : seq_q;

  // payload stages, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      p1_reply_r   <= res_reply;
      p1_store_r   <= rd_store;
      p1_hit_r     <= res_hit;
      p1_seq_len_r <= res_seq_len;
      p1_pic_len_r <= res_pic_len;
    end
    if (p1_move && p1_valid_r) begin
      out_tuser_r <= p1_reply_r;
      out_tdata_r <= {(p1_seq_len_r != 8'd0) && (p1_pic_len_r != 7'd0),
                      p1_pic_len_r, p1_seq_len_r, p1_rd};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

### sim/annexb_sps_pps_extractor_core_test.sv
`timescale 1ns / 100ps
// annexb_sps_pps_extractor_core_test: self-checking bench for the annex b sps/pps extractor
// depends on aspe_pkg and annexb_sps_pps_extractor_core; a behavioral tracker predicts results
module annexb_sps_pps_extractor_core_test;
  import aspe_pkg::*;

  typedef struct {
    logic       req;
    logic [7:0] data;
    logic       last;
    logic       rkind;
    logic [6:0] ridx;
  } in_word_t;

  typedef struct {
    logic       reply;
    logic [7:0] rdata;
    logic [7:0] seq_len;
    logic [6:0] pic_len;
    logic       both;
  } out_word_t;

  localparam int LIMIT_CYCLES = 400000;
  localparam int WORDS_WANTED = 700;
  localparam int HOLD_AT      = 500;  // words taken before the long output hold-off
  localparam int HOLD_CYCLES  = 90;
  localparam int MAX_PRINTS   = 40;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;

  annexb_sps_pps_extractor_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  in_word_t  words_to_send[$];
  out_word_t replies_due[$];
  in_word_t  cur_word;
  logic      in_fire = 1'b0;
  int        taken = 0;
  int        results_seen = 0;
  int        statuses_seen = 0;
  int        buffers_sent = 0;
  int        errors = 0;
  int        cycles = 0;
  int        hold_left = 0;
  logic      hold_done = 1'b0;
  wire       calm = (taken >= 250) && (taken < 400);

  // tracked copy of the extractor state
  logic [1:0] zrun;
  logic [1:0] phase;
  logic [1:0] ukind;
  int         ucount;
  logic [7:0] seq_mem [0:2*SEQ_MAX_BYTES-1];
  logic [7:0] pic_mem [0:2*PIC_MAX_BYTES-1];
  logic [7:0] seq_held;
  logic [6:0] pic_held;
  logic [1:0] bank;

  function automatic logic [1:0] bump_zeros(input logic [1:0] run, input logic [7:0] b);
    if (b != 8'h00) return 2'd0;
    return (run == 2'd3) ? 2'd3 : run + 2'd1;
  endfunction

  function automatic out_word_t held_word(input logic reply, input logic [7:0] d);
    out_word_t r;
    r.reply   = reply;
    r.rdata   = d;
    r.seq_len = seq_held;
    r.pic_len = pic_held;
    r.both    = (seq_held != 0) && (pic_held != 0);
    return r;
  endfunction

  // unit bytes go to the bank that is not being read
  task automatic keep_byte(input int idx, input logic [7:0] b);
    if (ukind == KIND_SEQ && idx < SEQ_MAX_BYTES)
      seq_mem[(bank[0] ? 0 : SEQ_MAX_BYTES) + idx] = b;
    else if (ukind == KIND_PIC && idx < PIC_MAX_BYTES)
      pic_mem[(bank[1] ? 0 : PIC_MAX_BYTES) + idx] = b;
  endtask

  task automatic close_unit(input int len);
    if (ukind == KIND_SEQ && len > 0 && len <= SEQ_MAX_BYTES) begin
      bank[0]  = ~bank[0];
      seq_held = 8'(len);
    end else if (ukind == KIND_PIC && len > 0 && len <= PIC_MAX_BYTES) begin
      bank[1]  = ~bank[1];
      pic_held = 7'(len);
    end
    ukind  = KIND_NONE;
    ucount = 0;
  endtask

  task automatic track_word(input in_word_t w);
    out_word_t  r;
    logic [4:0] nal;
    int         lim;
    if (w.req == REQ_READ) begin
      r = held_word(1'b1, 8'h00);
      if (w.rkind == STORE_SEQ) begin
        if (w.ridx < seq_held) r.rdata = seq_mem[(bank[0] ? SEQ_MAX_BYTES : 0) + w.ridx];
      end else begin
        if (w.ridx < pic_held) r.rdata = pic_mem[(bank[1] ? PIC_MAX_BYTES : 0) + w.ridx];
      end
      replies_due.push_back(r);
    end else begin
      case (phase)
        PH_SEARCH: begin
          seq_held = '0;
          pic_held = '0;
          if (w.data == 8'h01 && zrun >= 2) begin
            phase = PH_HEADER;
            zrun  = 2'd0;
          end else begin
            zrun = bump_zeros(zrun, w.data);
          end
        end
        PH_HEADER: begin
          nal    = 5'(w.data & NAL_TYPE_MASK);
          ukind  = (nal == NAL_TYPE_SPS) ? KIND_SEQ : (nal == NAL_TYPE_PPS) ? KIND_PIC : KIND_NONE;
          ucount = 1;
          keep_byte(0, w.data);
          zrun   = (w.data == 8'h00) ? 2'd1 : 2'd0;
          phase  = PH_UNIT;
        end
        PH_UNIT: begin
          if (w.data == 8'h01 && zrun >= 2) begin
            close_unit(ucount - 2);
            zrun  = 2'd0;
            phase = (seq_held != 0 && pic_held != 0) ? PH_DONE : PH_HEADER;
          end else begin
            lim = (ukind == KIND_SEQ) ? SEQ_MAX_BYTES : (ukind == KIND_PIC) ? PIC_MAX_BYTES : 0;
            keep_byte(ucount, w.data);
            if (ucount < lim + 3) ucount++;
            zrun = bump_zeros(zrun, w.data);
          end
        end
        default: ;
      endcase
      if (w.last) begin
        if (phase == PH_UNIT) close_unit(ucount);
        replies_due.push_back(held_word(1'b0, 8'h00));
        zrun   = 2'd0;
        ukind  = KIND_NONE;
        ucount = 0;
        phase  = PH_SEARCH;
      end
    end
  endtask

  task automatic push_read_at(input logic kind, input logic [6:0] idx, input logic last);
    in_word_t w;
    w.req   = REQ_READ;
    w.data  = 8'($urandom_range(0, 255));
    w.last  = last;
    w.rkind = kind;
    w.ridx  = idx;
    words_to_send.push_back(w);
  endtask

  task automatic push_read();
    logic [6:0] idx;
    idx = ($urandom_range(0, 2) == 0) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(0, 15));
    push_read_at(1'($urandom_range(0, 1)), idx, 1'($urandom_range(0, 1)));
  endtask

  // one buffer of stream bytes, last flag on its final byte; mix adds stray reads
  task automatic push_bytes(input logic [7:0] q[$], input logic mix);
    in_word_t w;
    foreach (q[i]) begin
      if (mix && $urandom_range(0, 19) == 0) push_read();
      w.req   = REQ_STREAM;
      w.data  = q[i];
      w.last  = (i == q.size() - 1);
      w.rkind = 1'($urandom_range(0, 1));
      w.ridx  = 7'($urandom_range(0, 127));
      words_to_send.push_back(w);
    end
    buffers_sent++;
  endtask

  task automatic push_buffer();
    logic [7:0] q[$];
    logic [7:0] hdr;
    int         units;
    int         body;
    int         lim;
    int         pick;
    if ($urandom_range(0, 11) == 0) begin
      // noise buffer, no forced start code
      repeat ($urandom_range(3, 20)) q.push_back(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 6)) q.push_back(8'($urandom_range(0, 255)));
      units = $urandom_range(1, 5);
      for (int u = 0; u < units; u++) begin
        if ($urandom_range(0, 3) == 0) q.push_back(8'h00);
        q.push_back(8'h00);
        q.push_back(8'h00);
        q.push_back(8'h01);
        pick = $urandom_range(0, 4);
        if (pick < 2) begin
          hdr = {3'($urandom_range(0, 7)), NAL_TYPE_SPS};
          lim = SEQ_MAX_BYTES;
        end else if (pick < 4) begin
          hdr = {3'($urandom_range(0, 7)), NAL_TYPE_PPS};
          lim = PIC_MAX_BYTES;
        end else begin
          hdr = 8'($urandom_range(0, 255));
          lim = 16;
        end
        q.push_back(hdr);
        pick = $urandom_range(0, 9);
        // unit length is body + 1; aim most units short, some at the size edge
        if (pick < 7) body = $urandom_range(0, 10);
        else if (pick < 9) body = lim - 3 + $urandom_range(0, 5);
        else body = lim + $urandom_range(2, 12);
        repeat (body)
          q.push_back(($urandom_range(0, 5) == 0) ? 8'h00 : 8'($urandom_range(0, 255)));
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        q.push_back(8'h00);
        q.push_back(8'h00);
        q.push_back(8'h01);
      end else if (pick == 1) begin
        q.push_back(8'h00);
        q.push_back(8'h00);
      end
    end
    push_bytes(q, 1'b1);
    repeat ($urandom_range(2, 10)) push_read();
  endtask

  task automatic report_miss(input string what, input int got, input int want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("%0t: %s got %0h want %0h", $realtime, what, got, want);
  endtask

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (words_to_send.size() != 0 && (calm || $urandom_range(0, 99) >= 16)) begin
        cur_word  = words_to_send.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {cur_word.ridx, cur_word.rkind, cur_word.data};
        in_tuser  <= cur_word.req;
        in_tlast  <= cur_word.last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // output ready, with one long hold-off so the block backs up
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (!hold_done && taken >= HOLD_AT) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      hold_done  <= 1'b1;
    end else begin
      out_tready <= calm || ($urandom_range(0, 99) >= 16);
    end
  end

  // monitor: predict on each accepted word, check each accepted result
  always @(posedge clk) begin
    out_word_t want;
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("annexb_sps_pps_extractor_core: mismatch");
      $finish;
    end
    in_fire = rst_n && in_tvalid && in_tready;
    if (in_fire) begin
      track_word(cur_word);
      taken++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (replies_due.size() == 0) begin
        report_miss("word with nothing due", out_tdata, 0);
      end else begin
        want = replies_due.pop_front();
        if (want.reply == 1'b0) statuses_seen++;
        if (out_tuser != want.reply) report_miss("is_read_reply", out_tuser, want.reply);
        if (out_tdata[7:0] != want.rdata) report_miss("read_data", out_tdata[7:0], want.rdata);
        if (out_tdata[15:8] != want.seq_len)
          report_miss("seq_set_length", out_tdata[15:8], want.seq_len);
        if (out_tdata[22:16] != want.pic_len)
          report_miss("pic_set_length", out_tdata[22:16], want.pic_len);
        if (out_tdata[23] != want.both) report_miss("found_both", out_tdata[23], want.both);
      end
    end
  end

  initial begin
    logic [7:0] q[$];
    zrun     = 2'd0;
    phase    = PH_SEARCH;
    ukind    = KIND_NONE;
    ucount   = 0;
    seq_held = '0;
    pic_held = '0;
    bank     = 2'd0;

    // extra zero before the first start code, sps, pps with a trailing zero kept,
    // then a byte after both are held, which is ignored
    q = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h67, 8'hAA, 8'h00, 8'h00, 8'h01,
          8'h68, 8'hBB, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h01, 8'h65};
    push_bytes(q, 1'b0);
    push_read_at(STORE_SEQ, 7'd0, 1'b0);
    push_read_at(STORE_SEQ, 7'd1, 1'b0);
    push_read_at(STORE_SEQ, 7'd2, 1'b1);
    push_read_at(STORE_PIC, 7'd3, 1'b0);
    push_read_at(STORE_PIC, 7'd127, 1'b0);
    // buffer that ends right on a start code
    q = '{8'h00, 8'h00, 8'h01};
    push_bytes(q, 1'b0);

    while (words_to_send.size() < WORDS_WANTED) push_buffer();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (words_to_send.size() != 0 || in_tvalid) @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (replies_due.size() != 0) report_miss("results never seen", replies_due.size(), 0);
    $display("%0d words in %0d buffers taken; %0d results checked, %0d of them end statuses",
             taken, buffers_sent, results_seen, statuses_seen);
    $display("output held off %0d cycles once; %0d field errors", HOLD_CYCLES, errors);
    if (errors == 0) begin
      $display("annexb_sps_pps_extractor_core: match");
    end else begin
      $display("annexb_sps_pps_extractor_core: mismatch");
    end
    $finish;
  end

endmodule

### annexb_sps_pps_extractor_core.f
design/aspe_pkg.sv
design/aspe_bank_ram.sv
design/annexb_sps_pps_extractor_core.sv
sim/annexb_sps_pps_extractor_core_test.sv
